### src/bcr_pkg.sv
// bcr_pkg: shared types, widths and codes for the bilinear cell resampler.
// No dependencies; bcr_coord, bcr_blend, the top level, the checker and the testbench import it.
package bcr_pkg;

   localparam int MAX_SOURCE_DIM_DEF = 256;
   localparam int FRACTION_BITS_DEF  = 8;

   localparam int TEXEL_ADDR_W = 16;
   localparam int TEXEL_DEPTH  = 65536;
   localparam int RGBA_W       = 32;
   localparam int CELL_W       = 10;
   localparam int LOCAL_W      = 8;
   localparam int MASK_W       = 8;
   localparam int DIM_REG_W    = 9;
   localparam int OVERLAY_W    = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 10;
   localparam int BLEND_LAT    = 6;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_WIDTH  = 3'd0,
      CSR_SOURCE_HEIGHT = 3'd1,
      CSR_CELL_SIZE     = 3'd2,
      CSR_GRID_MIN_X    = 3'd3,
      CSR_GRID_MAX_X    = 3'd4,
      CSR_GRID_MIN_Y    = 3'd5,
      CSR_GRID_MAX_Y    = 3'd6
   } csr_index_type;

   // payload travelling alongside the coordinate pipeline
   typedef struct packed {
      logic                    load;
      logic [TEXEL_ADDR_W-1:0] texel_index;
      logic [RGBA_W-1:0]       texel_rgba;
      logic [MASK_W-1:0]       land_mask;
      logic                    out_of_grid;
      logic [OVERLAY_W-1:0]    overlay_x;
      logic [OVERLAY_W-1:0]    overlay_y;
   } carry_type;

   // payload travelling alongside the blend pipeline
   typedef struct packed {
      logic                 out_of_grid;
      logic [OVERLAY_W-1:0] overlay_x;
      logic [OVERLAY_W-1:0] overlay_y;
   } tail_type;

   function automatic int dim_width(input int max_dim);
      return $clog2(max_dim + 1);
   endfunction

   function automatic int index_width(input int max_dim);
      return $clog2(max_dim);
   endfunction

   // dividend width of the coordinate divider, one quotient bit per stage
   function automatic int quot_width(input int max_dim, input int frac);
      return LOCAL_W + 1 + dim_width(max_dim) + frac + 2;
   endfunction

   function automatic int coord_latency(input int max_dim, input int frac);
      return quot_width(max_dim, frac) + 3;
   endfunction

endpackage

### src/bcr_ram.sv
// bcr_ram: generic simple dual-port RAM, one write and one registered read.
// Depends on nothing.
module bcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bcr_delay.sv
// bcr_delay: stalling shift line, valid bits reset, payload not.
// Depends on nothing.
module bcr_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             valid_in,
   input  logic [WIDTH-1:0] data_in,
   output logic             valid_out,
   output logic [WIDTH-1:0] data_out
);

   logic             valid_ff [DEPTH];
   logic [WIDTH-1:0] data_ff  [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= valid_in;
         for (int k = 1; k < DEPTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff[0] <= data_in;
         for (int k = 1; k < DEPTH; k++) begin
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign valid_out = valid_ff[DEPTH-1];
   assign data_out  = data_ff[DEPTH-1];

endmodule

### src/bcr_coord.sv
// bcr_coord: fixed-point source coordinate for one axis, pipelined divider.
// Depends on bcr_pkg.
module bcr_coord import bcr_pkg::*; #(
   parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_DEF,
   parameter int FRACTION_BITS  = FRACTION_BITS_DEF,
   localparam int DIM_W = dim_width(MAX_SOURCE_DIM),
   localparam int IDX_W = index_width(MAX_SOURCE_DIM)
) (
   input  logic                     clock,
   input  logic                     advance,
   input  logic [LOCAL_W-1:0]       coord,
   input  logic [DIM_W-1:0]         dim,
   input  logic [DIM_REG_W-1:0]     cell_side,
   output logic [IDX_W-1:0]         idx0,
   output logic [IDX_W-1:0]         idx1,
   output logic [FRACTION_BITS-1:0] frac
);

   localparam int A_W = LOCAL_W + 1 + DIM_W;
   localparam int N_W = quot_width(MAX_SOURCE_DIM, FRACTION_BITS);
   localparam int D_W = DIM_REG_W + 2;
   localparam int S_W = IDX_W + FRACTION_BITS;

   logic [A_W-1:0] a_ff;
   logic [N_W-1:0] num_in;
   logic [D_W-1:0] divisor;
   logic [N_W-1:0] n_ff   [N_W];
   logic [D_W-1:0] rem_ff [1:N_W-1];
   logic [N_W-1:0] q_ff   [1:N_W];

   // (2d+1)*dim
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= A_W'({coord, 1'b1}) * A_W'(dim);
      end
   end

   // dividend (num << F+1) + 2cs, divisor 4cs; quotient rounds half up
   always_comb begin
      if (a_ff > A_W'(cell_side)) begin
         num_in = ((N_W'(a_ff) - N_W'(cell_side)) << (FRACTION_BITS + 1))
                + (N_W'(cell_side) << 1);
      end else begin
         num_in = '0;
      end
   end

   assign divisor = {cell_side, 2'b00};

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff[0] <= num_in;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < N_W; k++) begin : g_div
      logic [D_W-1:0] rem_cur;
      logic [N_W-1:0] q_cur;
      logic [D_W:0]   trial;
      logic           ge;

      if (k == 0) begin : g_first
         assign rem_cur = '0;
         assign q_cur   = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k];
         assign q_cur   = q_ff[k];
      end

      assign trial = {rem_cur, n_ff[k][N_W-1]};
      assign ge    = trial >= {1'b0, divisor};

      always_ff @(posedge clock) begin
         if (advance) begin
            q_ff[k+1] <= {q_cur[N_W-2:0], ge};
         end
      end

      if (k < N_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k+1] <= ge ? D_W'(trial - {1'b0, divisor}) : D_W'(trial);
               n_ff[k+1]   <= n_ff[k] << 1;
            end
         end
      end
   end

   logic [IDX_W-1:0]         last_idx;
   logic [S_W-1:0]           lim;
   logic [S_W-1:0]           s_in;
   logic [IDX_W-1:0]         i0_in;
   logic [IDX_W-1:0]         i1_in;
   logic [IDX_W-1:0]         idx0_ff;
   logic [IDX_W-1:0]         idx1_ff;
   logic [FRACTION_BITS-1:0] frac_ff;

   assign last_idx = IDX_W'(dim - DIM_W'(1));
   assign lim      = {last_idx, {FRACTION_BITS{1'b0}}};
   assign s_in     = (q_ff[N_W] > N_W'(lim)) ? lim : S_W'(q_ff[N_W]);
   assign i0_in    = s_in[S_W-1:FRACTION_BITS];
   assign i1_in    = (i0_in == last_idx) ? i0_in : i0_in + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (advance) begin
         idx0_ff <= i0_in;
         idx1_ff <= i1_in;
         frac_ff <= s_in[FRACTION_BITS-1:0];
      end
   end

   assign idx0 = idx0_ff;
   assign idx1 = idx1_ff;
   assign frac = frac_ff;

endmodule

### src/bcr_blend.sv
// bcr_blend: per-channel bilinear blend, rounding and alpha mask scaling.
// Depends on bcr_pkg.
module bcr_blend import bcr_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     advance,
   input  logic [RGBA_W-1:0]        p00,
   input  logic [RGBA_W-1:0]        p10,
   input  logic [RGBA_W-1:0]        p01,
   input  logic [RGBA_W-1:0]        p11,
   input  logic [FRACTION_BITS-1:0] fx,
   input  logic [FRACTION_BITS-1:0] fy,
   input  logic [MASK_W-1:0]        mask,
   output logic [RGBA_W-1:0]        pixel
);

   localparam int F   = FRACTION_BITS;
   localparam int T_W = 8 + F;
   localparam int V_W = 8 + 2 * F;
   localparam int U_W = V_W + MASK_W;
   localparam int H_W = U_W + 1 - 2 * F;
   localparam int P_W = H_W + 9;
   localparam int Q_W = P_W - 16;
   localparam logic [F:0]   ONE     = {1'b1, {F{1'b0}}};
   localparam logic [V_W:0] RND     = (V_W + 1)'(1) << (2 * F - 1);
   localparam logic [U_W:0] A_RND   = (U_W + 1)'(255) << (2 * F - 1);

   logic [F:0]       omfx;
   logic [F:0]       omfy;
   logic [T_W-1:0]   t0_ff [4];
   logic [T_W-1:0]   t1_ff [4];
   logic [F-1:0]     fy1_ff;
   logic [MASK_W-1:0] mask1_ff;
   logic [V_W-1:0]   v_ff [4];
   logic [MASK_W-1:0] mask2_ff;
   logic [23:0]      rgb3_ff;
   logic [23:0]      rgb4_ff;
   logic [23:0]      rgb5_ff;
   logic [23:0]      rgb6_ff;
   logic [U_W-1:0]   u_ff;
   logic [H_W-1:0]   hi_ff;
   logic [H_W-1:0]   hi5_ff;
   logic [P_W-1:0]   prod_in;
   logic [Q_W-1:0]   q0_ff;
   logic [H_W-1:0]   rem_in;
   logic [Q_W-1:0]   aq_in;
   logic [7:0]       alpha_ff;

   assign omfx = ONE - (F + 1)'(fx);
   assign omfy = ONE - (F + 1)'(fy1_ff);

   // horizontal lerp of both rows
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int ch = 0; ch < 4; ch++) begin
            t0_ff[ch] <= T_W'((T_W + 1)'(p00[8*ch +: 8]) * (T_W + 1)'(omfx)
                            + (T_W + 1)'(p10[8*ch +: 8]) * (T_W + 1)'(fx));
            t1_ff[ch] <= T_W'((T_W + 1)'(p01[8*ch +: 8]) * (T_W + 1)'(omfx)
                            + (T_W + 1)'(p11[8*ch +: 8]) * (T_W + 1)'(fx));
         end
         fy1_ff   <= fy;
         mask1_ff <= mask;
      end
   end

   // vertical lerp
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int ch = 0; ch < 4; ch++) begin
            v_ff[ch] <= V_W'((V_W + 1)'(t0_ff[ch]) * (V_W + 1)'(omfy)
                           + (V_W + 1)'(t1_ff[ch]) * (V_W + 1)'(fy1_ff));
         end
         mask2_ff <= mask1_ff;
      end
   end

   // colour rounding; alpha times mask
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int ch = 0; ch < 3; ch++) begin
            rgb3_ff[8*ch +: 8] <= 8'(((V_W + 1)'(v_ff[ch]) + RND) >> (2 * F));
         end
         u_ff <= U_W'(v_ff[3]) * U_W'(mask2_ff);
      end
   end

   // alpha / 255: rounding, reciprocal estimate, then one correction
   assign prod_in = P_W'(hi_ff) * P_W'(257);
   assign rem_in  = hi5_ff - H_W'(q0_ff) * H_W'(255);
   assign aq_in   = (rem_in >= H_W'(255)) ? q0_ff + Q_W'(1) : q0_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         hi_ff    <= H_W'(((U_W + 1)'(u_ff) + A_RND) >> (2 * F));
         rgb4_ff  <= rgb3_ff;
         q0_ff    <= prod_in[P_W-1:16];
         hi5_ff   <= hi_ff;
         rgb5_ff  <= rgb4_ff;
         alpha_ff <= (aq_in > Q_W'(255)) ? 8'd255 : aq_in[7:0];
         rgb6_ff  <= rgb5_ff;
      end
   end

   assign pixel = {alpha_ff, rgb6_ff};

endmodule

### src/bilinear_cell_resampler.sv
// bilinear_cell_resampler: top level; texel store, coordinate and blend pipelines.
// Depends on bcr_pkg, bcr_ram, bcr_delay, bcr_coord and bcr_blend.
//
//   channel  direction  handshake              beat carries
//   req_     in         req_valid/req_ready    texel load or pixel sample
//   rsp_     out        rsp_valid/rsp_ready    one pixel per sample beat
//   csr_     in         csr_valid/csr_ready    register index and data
//
// One beat per cycle in each direction while rsp_ is not stalled. The pipeline
// depth is set mostly by the one-bit-per-stage coordinate divider. Loads give
// no result. Reset restores the register defaults and empties the pipeline;
// the texel store is not cleared. A stalled rsp_ holds the whole pipe.
module bilinear_cell_resampler import bcr_pkg::*; #(
   parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_DEF,
   parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [TEXEL_ADDR_W-1:0] req_texel_index,
   input  logic [RGBA_W-1:0]       req_texel_rgba,
   input  logic signed [CELL_W-1:0] req_cell_x,
   input  logic signed [CELL_W-1:0] req_cell_y,
   input  logic [LOCAL_W-1:0]      req_local_x,
   input  logic [LOCAL_W-1:0]      req_local_y,
   input  logic [MASK_W-1:0]       req_land_mask,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RGBA_W-1:0]       rsp_pixel_rgba,
   output logic [OVERLAY_W-1:0]    rsp_overlay_x,
   output logic [OVERLAY_W-1:0]    rsp_overlay_y,
   output logic                    rsp_out_of_grid,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int DIM_W     = dim_width(MAX_SOURCE_DIM);
   localparam int IDX_W     = index_width(MAX_SOURCE_DIM);
   localparam int YW_W      = IDX_W + DIM_W;
   localparam int COORD_LAT = coord_latency(MAX_SOURCE_DIM, FRACTION_BITS);

   logic advance;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // ---------------- configuration ----------------
   logic [DIM_REG_W-1:0]     width_ff;
   logic [DIM_REG_W-1:0]     height_ff;
   logic [DIM_REG_W-1:0]     cell_size_ff;
   logic signed [CELL_W-1:0] grid_min_x_ff;
   logic signed [CELL_W-1:0] grid_max_x_ff;
   logic signed [CELL_W-1:0] grid_min_y_ff;
   logic signed [CELL_W-1:0] grid_max_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= DIM_REG_W'(256);
         height_ff     <= DIM_REG_W'(256);
         cell_size_ff  <= DIM_REG_W'(18);
         grid_min_x_ff <= '0;
         grid_max_x_ff <= '0;
         grid_min_y_ff <= '0;
         grid_max_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_WIDTH:  width_ff      <= csr_data[DIM_REG_W-1:0];
            CSR_SOURCE_HEIGHT: height_ff     <= csr_data[DIM_REG_W-1:0];
            CSR_CELL_SIZE:     cell_size_ff  <= csr_data[DIM_REG_W-1:0];
            CSR_GRID_MIN_X:    grid_min_x_ff <= csr_data[CELL_W-1:0];
            CSR_GRID_MAX_X:    grid_max_x_ff <= csr_data[CELL_W-1:0];
            CSR_GRID_MIN_Y:    grid_min_y_ff <= csr_data[CELL_W-1:0];
            CSR_GRID_MAX_Y:    grid_max_y_ff <= csr_data[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0]     w_eff;
   logic [DIM_W-1:0]     h_eff;
   logic [DIM_REG_W-1:0] cs_eff;

   // zero acts as one, oversize clamps to the store's side
   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_SOURCE_DIM)) begin
         w_eff = DIM_W'(MAX_SOURCE_DIM);
      end else begin
         w_eff = DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_SOURCE_DIM)) begin
         h_eff = DIM_W'(MAX_SOURCE_DIM);
      end else begin
         h_eff = DIM_W'(height_ff);
      end
   end

   assign cs_eff = (cell_size_ff == '0) ? DIM_REG_W'(1) : cell_size_ff;

   // ---------------- input register ----------------
   logic                     s0_valid_ff;
   logic                     s0_cmd_ff;
   logic [TEXEL_ADDR_W-1:0]  s0_index_ff;
   logic [RGBA_W-1:0]        s0_rgba_ff;
   logic signed [CELL_W-1:0] s0_cx_ff;
   logic signed [CELL_W-1:0] s0_cy_ff;
   logic [LOCAL_W-1:0]       s0_lx_ff;
   logic [LOCAL_W-1:0]       s0_ly_ff;
   logic [MASK_W-1:0]        s0_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_cmd_ff   <= req_cmd;
         s0_index_ff <= req_texel_index;
         s0_rgba_ff  <= req_texel_rgba;
         s0_cx_ff    <= req_cell_x;
         s0_cy_ff    <= req_cell_y;
         s0_lx_ff    <= req_local_x;
         s0_ly_ff    <= req_local_y;
         s0_mask_ff  <= req_land_mask;
      end
   end

   // grid test and overlay position
   logic                 oog;
   logic [CELL_W:0]      dx;
   logic [CELL_W:0]      dy;
   logic [OVERLAY_W-1:0] dx16;
   logic [OVERLAY_W-1:0] dy16;
   logic [OVERLAY_W-1:0] ox;
   logic [OVERLAY_W-1:0] oy;
   carry_type            carry_in;

   assign oog  = (s0_cx_ff < grid_min_x_ff) || (s0_cx_ff > grid_max_x_ff)
              || (s0_cy_ff < grid_min_y_ff) || (s0_cy_ff > grid_max_y_ff);
   assign dx   = {s0_cx_ff[CELL_W-1], s0_cx_ff} - {grid_min_x_ff[CELL_W-1], grid_min_x_ff};
   assign dy   = {s0_cy_ff[CELL_W-1], s0_cy_ff} - {grid_min_y_ff[CELL_W-1], grid_min_y_ff};
   assign dx16 = {{(OVERLAY_W - CELL_W - 1){dx[CELL_W]}}, dx};
   assign dy16 = {{(OVERLAY_W - CELL_W - 1){dy[CELL_W]}}, dy};
   assign ox   = dx16 * OVERLAY_W'(cs_eff) + OVERLAY_W'(s0_lx_ff);
   assign oy   = dy16 * OVERLAY_W'(cs_eff) + OVERLAY_W'(s0_ly_ff);

   always_comb begin
      carry_in.load        = (s0_cmd_ff == CMD_LOAD);
      carry_in.texel_index = s0_index_ff;
      carry_in.texel_rgba  = s0_rgba_ff;
      carry_in.land_mask   = s0_mask_ff;
      carry_in.out_of_grid = oog;
      carry_in.overlay_x   = oog ? '0 : ox;
      carry_in.overlay_y   = oog ? '0 : oy;
   end

   // ---------------- coordinates ----------------
   logic [IDX_W-1:0]         x0;
   logic [IDX_W-1:0]         x1;
   logic [IDX_W-1:0]         y0;
   logic [IDX_W-1:0]         y1;
   logic [FRACTION_BITS-1:0] fx;
   logic [FRACTION_BITS-1:0] fy;
   logic                     head_valid;
   carry_type                head_carry;

   bcr_coord #(
      .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_coord_x (
      .clock     (clock),
      .advance   (advance),
      .coord     (s0_lx_ff),
      .dim       (w_eff),
      .cell_side (cs_eff),
      .idx0      (x0),
      .idx1      (x1),
      .frac      (fx)
   );

   bcr_coord #(
      .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_coord_y (
      .clock     (clock),
      .advance   (advance),
      .coord     (s0_ly_ff),
      .dim       (h_eff),
      .cell_side (cs_eff),
      .idx0      (y0),
      .idx1      (y1),
      .frac      (fy)
   );

   bcr_delay #(
      .WIDTH ($bits(carry_type)),
      .DEPTH (COORD_LAT)
   ) u_head_delay (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (s0_valid_ff),
      .data_in   (carry_in),
      .valid_out (head_valid),
      .data_out  (head_carry)
   );

   // ---------------- row bases ----------------
   logic                     m_valid_ff;
   carry_type                m_carry_ff;
   logic [YW_W-1:0]          m_yw0_ff;
   logic [YW_W-1:0]          m_yw1_ff;
   logic [IDX_W-1:0]         m_x0_ff;
   logic [IDX_W-1:0]         m_x1_ff;
   logic [FRACTION_BITS-1:0] m_fx_ff;
   logic [FRACTION_BITS-1:0] m_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_carry_ff <= head_carry;
         m_yw0_ff   <= YW_W'(y0) * YW_W'(w_eff);
         m_yw1_ff   <= YW_W'(y1) * YW_W'(w_eff);
         m_x0_ff    <= x0;
         m_x1_ff    <= x1;
         m_fx_ff    <= fx;
         m_fy_ff    <= fy;
      end
   end

   // ---------------- texel store, one copy per corner ----------------
   logic [TEXEL_ADDR_W-1:0] rd_addr [4];
   logic [RGBA_W-1:0]       rd_data [4];
   logic                    wr_en;

   // address wraps to the store size
   assign rd_addr[0] = TEXEL_ADDR_W'((YW_W + 1)'(m_yw0_ff) + (YW_W + 1)'(m_x0_ff));
   assign rd_addr[1] = TEXEL_ADDR_W'((YW_W + 1)'(m_yw0_ff) + (YW_W + 1)'(m_x1_ff));
   assign rd_addr[2] = TEXEL_ADDR_W'((YW_W + 1)'(m_yw1_ff) + (YW_W + 1)'(m_x0_ff));
   assign rd_addr[3] = TEXEL_ADDR_W'((YW_W + 1)'(m_yw1_ff) + (YW_W + 1)'(m_x1_ff));
   assign wr_en      = advance && m_valid_ff && m_carry_ff.load;

   for (genvar k = 0; k < 4; k++) begin : g_bank
      bcr_ram #(
         .WIDTH (RGBA_W),
         .DEPTH (TEXEL_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (m_carry_ff.texel_index),
         .wr_data (m_carry_ff.texel_rgba),
         .rd_en   (advance),
         .rd_addr (rd_addr[k]),
         .rd_data (rd_data[k])
      );
   end

   // ---------------- read stage ----------------
   logic                     r_valid_ff;
   tail_type                 r_tail_ff;
   logic [FRACTION_BITS-1:0] r_fx_ff;
   logic [FRACTION_BITS-1:0] r_fy_ff;
   logic [MASK_W-1:0]        r_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (advance) begin
         r_valid_ff <= m_valid_ff && !m_carry_ff.load;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_tail_ff.out_of_grid <= m_carry_ff.out_of_grid;
         r_tail_ff.overlay_x   <= m_carry_ff.overlay_x;
         r_tail_ff.overlay_y   <= m_carry_ff.overlay_y;
         r_fx_ff               <= m_fx_ff;
         r_fy_ff               <= m_fy_ff;
         r_mask_ff             <= m_carry_ff.land_mask;
      end
   end

   // ---------------- blend and result ----------------
   logic [RGBA_W-1:0] blend_pixel;
   tail_type          out_tail;

   bcr_blend #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_blend (
      .clock   (clock),
      .advance (advance),
      .p00     (rd_data[0]),
      .p10     (rd_data[1]),
      .p01     (rd_data[2]),
      .p11     (rd_data[3]),
      .fx      (r_fx_ff),
      .fy      (r_fy_ff),
      .mask    (r_mask_ff),
      .pixel   (blend_pixel)
   );

   bcr_delay #(
      .WIDTH ($bits(tail_type)),
      .DEPTH (BLEND_LAT)
   ) u_tail_delay (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (r_valid_ff),
      .data_in   (r_tail_ff),
      .valid_out (rsp_valid),
      .data_out  (out_tail)
   );

   assign rsp_pixel_rgba  = out_tail.out_of_grid ? '0 : blend_pixel;
   assign rsp_overlay_x   = out_tail.overlay_x;
   assign rsp_overlay_y   = out_tail.overlay_y;
   assign rsp_out_of_grid = out_tail.out_of_grid;

endmodule

### src/bcr_checker.sv
// bcr_checker: port-level assertions for the resampler, bound to the top level.
// Depends on bcr_pkg.
module bcr_checker import bcr_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [RGBA_W-1:0]    rsp_pixel_rgba,
   input logic [OVERLAY_W-1:0] rsp_overlay_x,
   input logic [OVERLAY_W-1:0] rsp_overlay_y,
   input logic                 rsp_out_of_grid
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_rgba)
         && $stable(rsp_overlay_x) && $stable(rsp_overlay_y) && $stable(rsp_out_of_grid))
      else $error("result beat changed while stalled");

   // an off-grid result carries no pixel and no position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_grid |-> rsp_pixel_rgba == '0
         && rsp_overlay_x == '0 && rsp_overlay_y == '0)
      else $error("off-grid result with non-zero payload");

   // pipe never refuses input while the output side is free
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input refused with output free");

   // reset empties the pipe
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind bilinear_cell_resampler bcr_checker u_bcr_checker (.*);

### verif/tb_top.sv
// tb_top: self-checking testbench for bilinear_cell_resampler.
// Depends on bcr_pkg and the RTL; holds its own pixel predictor and result store.
`timescale 1ns / 100ps

module tb_top;
   import bcr_pkg::*;

   localparam int FRAC     = FRACTION_BITS_DEF;
   localparam int MAX_DIM  = MAX_SOURCE_DIM_DEF;
   localparam int SETTLE   = 64;

   typedef struct {
      cmd_type     cmd;
      logic [15:0] texel_index;
      logic [31:0] texel_rgba;
      int          cell_x;
      int          cell_y;
      logic [7:0]  local_x;
      logic [7:0]  local_y;
      logic [7:0]  land_mask;
   } pixel_req;

   typedef struct {
      logic [31:0] pixel_rgba;
      logic [15:0] overlay_x;
      logic [15:0] overlay_y;
      logic        out_of_grid;
   } pixel_rsp;

   class pixel_scoreboard;
      logic [31:0] texels [int];
      pixel_rsp    pending_px [$];
      int          src_w = 256, src_h = 256, cell_sz = 18;
      int          gmin_x = 0, gmax_x = 0, gmin_y = 0, gmax_y = 0;
      int          fails = 0;

      function int sext(logic [9:0] v);
         return $signed(v);
      endfunction

      function void write_reg(csr_index_type idx, logic [9:0] d);
         case (idx)
            CSR_SOURCE_WIDTH:  src_w   = d[8:0];
            CSR_SOURCE_HEIGHT: src_h   = d[8:0];
            CSR_CELL_SIZE:     cell_sz = d[8:0];
            CSR_GRID_MIN_X:    gmin_x  = sext(d);
            CSR_GRID_MAX_X:    gmax_x  = sext(d);
            CSR_GRID_MIN_Y:    gmin_y  = sext(d);
            CSR_GRID_MAX_Y:    gmax_y  = sext(d);
            default: ;
         endcase
      endfunction

      function int clamp_dim(int v);
         if (v < 1) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      function int eff_cell();
         return (cell_sz == 0) ? 1 : cell_sz;
      endfunction

      function bit in_grid(pixel_req r);
         return !(r.cell_x < gmin_x || r.cell_x > gmax_x ||
                  r.cell_y < gmin_y || r.cell_y > gmax_y);
      endfunction

      // fixed-point source coordinate, clamped to the last texel
      function longint unsigned src_pos(int d, int dim, int cs);
         longint unsigned a, q, lim;
         a   = (2 * longint'(d) + 1) * dim;
         q   = 0;
         lim = longint'(dim - 1) << FRAC;
         if (a > cs)
            q = (((a - cs) << (FRAC + 1)) + 2 * cs) / (4 * cs);
         return (q > lim) ? lim : q;
      endfunction

      // addresses of the four taps: 00, 10, 01, 11
      function void taps(pixel_req r, output int a[4], output int fx, output int fy);
         int w, h, cs, x0, x1, y0, y1;
         longint unsigned sx, sy;
         w  = clamp_dim(src_w);
         h  = clamp_dim(src_h);
         cs = eff_cell();
         sx = src_pos(r.local_x, w, cs);
         sy = src_pos(r.local_y, h, cs);
         x0 = sx >> FRAC;
         y0 = sy >> FRAC;
         fx = sx & ((1 << FRAC) - 1);
         fy = sy & ((1 << FRAC) - 1);
         x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
         y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
         a[0] = (y0 * w + x0) & 16'hFFFF;
         a[1] = (y0 * w + x1) & 16'hFFFF;
         a[2] = (y1 * w + x0) & 16'hFFFF;
         a[3] = (y1 * w + x1) & 16'hFFFF;
      endfunction

      function void note_request(pixel_req r);
         pixel_rsp e;
         int a[4];
         int fx, fy, diff;
         longint unsigned one, t0, t1, v, b, den;
         logic [31:0] p [4];
         if (r.cmd == CMD_LOAD) begin
            texels[r.texel_index] = r.texel_rgba;
            return;
         end
         e = '{default: 0};
         if (!in_grid(r)) begin
            e.out_of_grid = 1'b1;
            pending_px.push_back(e);
            return;
         end
         taps(r, a, fx, fy);
         for (int i = 0; i < 4; i++)
            p[i] = texels.exists(a[i]) ? texels[a[i]] : 32'h0;
         one = 1 << FRAC;
         den = 255 * one * one;
         for (int ch = 0; ch < 4; ch++) begin
            t0 = p[0][ch*8 +: 8] * (one - fx) + p[1][ch*8 +: 8] * fx;
            t1 = p[2][ch*8 +: 8] * (one - fx) + p[3][ch*8 +: 8] * fx;
            v  = t0 * (one - fy) + t1 * fy;
            if (ch < 3) b = (v + one * one / 2) / (one * one);
            else        b = (2 * v * r.land_mask + den) / (2 * den);
            if (b > 255) b = 255;
            e.pixel_rgba[ch*8 +: 8] = b[7:0];
         end
         diff = r.cell_x - gmin_x;
         e.overlay_x = diff * eff_cell() + r.local_x;
         diff = r.cell_y - gmin_y;
         e.overlay_y = diff * eff_cell() + r.local_y;
         pending_px.push_back(e);
      endfunction

      function void check_result(pixel_rsp got);
         pixel_rsp e;
         if (pending_px.size() == 0) begin
            $error("pixel beat with nothing expected");
            fails++;
            return;
         end
         e = pending_px.pop_front();
         if (got.pixel_rgba !== e.pixel_rgba) begin
            $error("pixel_rgba expected %h actual %h", e.pixel_rgba, got.pixel_rgba);
            fails++;
         end
         if (got.overlay_x !== e.overlay_x) begin
            $error("overlay_x expected %0d actual %0d", e.overlay_x, got.overlay_x);
            fails++;
         end
         if (got.overlay_y !== e.overlay_y) begin
            $error("overlay_y expected %0d actual %0d", e.overlay_y, got.overlay_y);
            fails++;
         end
         if (got.out_of_grid !== e.out_of_grid) begin
            $error("out_of_grid expected %b actual %b", e.out_of_grid, got.out_of_grid);
            fails++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_cmd = 1'b0;
   logic [TEXEL_ADDR_W-1:0] req_texel_index = '0;
   logic [RGBA_W-1:0]       req_texel_rgba = '0;
   logic signed [CELL_W-1:0] req_cell_x = '0;
   logic signed [CELL_W-1:0] req_cell_y = '0;
   logic [LOCAL_W-1:0]      req_local_x = '0;
   logic [LOCAL_W-1:0]      req_local_y = '0;
   logic [MASK_W-1:0]       req_land_mask = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [RGBA_W-1:0]       rsp_pixel_rgba;
   logic [OVERLAY_W-1:0]    rsp_overlay_x;
   logic [OVERLAY_W-1:0]    rsp_overlay_y;
   logic                    rsp_out_of_grid;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   pixel_scoreboard sb = new();
   bit quiet = 1'b0;   // no idling on either side while set

   bilinear_cell_resampler i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function int draw_gap();
      return quiet ? 0 : $urandom_range(18, 0);
   endfunction

   task automatic send_beat(pixel_req r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_cmd         <= r.cmd;
      req_texel_index <= r.texel_index;
      req_texel_rgba  <= r.texel_rgba;
      req_cell_x      <= r.cell_x[9:0];
      req_cell_y      <= r.cell_y[9:0];
      req_local_x     <= r.local_x;
      req_local_y     <= r.local_y;
      req_land_mask   <= r.land_mask;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic load_texel(int idx, logic [31:0] rgba);
      pixel_req r;
      r = '{cmd: CMD_LOAD, texel_index: idx, texel_rgba: rgba, default: 0};
      r.cell_x = $urandom_range(1023) - 512;
      r.cell_y = $urandom_range(1023) - 512;
      send_beat(r);
   endtask

   // for an in-grid sample, loads any tap not yet written; then the sample itself
   task automatic sample_pixel(pixel_req r);
      int a[4];
      int fx, fy;
      r.cmd = CMD_SAMPLE;
      if (sb.in_grid(r)) begin
         sb.taps(r, a, fx, fy);
         foreach (a[i])
            if (!sb.texels.exists(a[i])) load_texel(a[i], $urandom());
      end
      send_beat(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_px.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int val);
      csr_index <= idx;
      csr_data  <= val[9:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, val[9:0]);
   endtask

   task automatic set_layout(int w, int h, int cs, int x0, int x1, int y0, int y1);
      write_reg(CSR_SOURCE_WIDTH, w);
      write_reg(CSR_SOURCE_HEIGHT, h);
      write_reg(CSR_CELL_SIZE, cs);
      write_reg(CSR_GRID_MIN_X, x0);
      write_reg(CSR_GRID_MAX_X, x1);
      write_reg(CSR_GRID_MIN_Y, y0);
      write_reg(CSR_GRID_MAX_Y, y1);
   endtask

   function automatic int pick_cell(int lo, int hi);
      if (lo > hi || $urandom_range(9) == 0) return $urandom_range(1023) - 512;
      return lo + $urandom_range(hi - lo);
   endfunction

   task automatic random_burst(int n);
      pixel_req r;
      int cs;
      cs = sb.eff_cell();
      repeat (n) begin
         if ($urandom_range(3) == 0) begin
            load_texel($urandom_range(16'hFFFF), $urandom());
         end else begin
            r = '{cmd: CMD_SAMPLE, texel_index: $urandom(), texel_rgba: $urandom(),
                  default: 0};
            r.cell_x    = pick_cell(sb.gmin_x, sb.gmax_x);
            r.cell_y    = pick_cell(sb.gmin_y, sb.gmax_y);
            r.local_x   = ($urandom_range(7) == 0) ? $urandom_range(255)
                        : $urandom_range((cs > 256 ? 256 : cs) - 1);
            r.local_y   = ($urandom_range(7) == 0) ? $urandom_range(255)
                        : $urandom_range((cs > 256 ? 256 : cs) - 1);
            r.land_mask = ($urandom_range(3) == 0) ? 8'hFF : $urandom_range(255);
            sample_pixel(r);
         end
      end
   endtask

   task automatic directed_sample(int cx, int cy, int lx, int ly, int m);
      pixel_req r;
      r = '{cmd: CMD_SAMPLE, cell_x: cx, cell_y: cy, local_x: lx, local_y: ly,
            land_mask: m, default: 0};
      sample_pixel(r);
   endtask

   // result side: random stall before each beat
   initial begin
      int stall;
      pixel_rsp got;
      @(negedge reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.pixel_rgba  = rsp_pixel_rgba;
         got.overlay_x   = rsp_overlay_x;
         got.overlay_y   = rsp_overlay_y;
         got.out_of_grid = rsp_out_of_grid;
         sb.check_result(got);
      end
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int cfg [8][7] = '{
         '{256, 256,  18,    0,    0,    0,    0},
         '{  4,   3,   5,   -2,    2,   -1,    1},
         '{  1,   1,   1, -512,  511, -512,  511},
         '{  0,   0,   0,   -3,    3,   -3,    3},
         '{511, 300, 256, -512, -500,  500,  511},
         '{256, 256, 511,    3,    2,    0,    0},
         '{ 17, 200,   7,  -30,   40,  -10,   10},
         '{  2, 256, 255,  100,  120, -120, -100}};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: extremes of every field
      load_texel(0, 32'h0000_0000);
      load_texel(16'hFFFF, 32'hFFFF_FFFF);
      load_texel(16'h5555, 32'hA5A5_5A5A);
      directed_sample(0, 0, 0, 0, 255);
      directed_sample(0, 0, 255, 255, 0);
      directed_sample(0, 0, 17, 17, 128);
      directed_sample(0, 0, 18, 0, 255);
      directed_sample(0, 0, 9, 3, 1);
      directed_sample(-512, 511, 0, 0, 255);
      directed_sample(511, -512, 5, 5, 255);
      directed_sample(1, 0, 0, 0, 255);
      directed_sample(0, -1, 0, 0, 255);
      random_burst(30);
      drain();   // sender holds off until every result is in

      for (int ph = 0; ph < 8; ph++) begin
         set_layout(cfg[ph][0], cfg[ph][1], cfg[ph][2], cfg[ph][3],
                    cfg[ph][4], cfg[ph][5], cfg[ph][6]);
         quiet = ($urandom_range(3) == 0);
         directed_sample(sb.gmin_x, sb.gmin_y, 0, 0, 255);
         directed_sample(sb.gmax_x, sb.gmax_y, 255, 255, 0);
         random_burst(45);
         quiet = 1'b0;
         drain();
      end

      if (sb.fails == 0 && sb.pending_px.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
